[rtl/core/rfb_pkg.sv]
// Package for the reply frame builder: frame constants, item field types
// and the byte-wide reflected CRC-32 update. No dependencies.
package rfb_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_len;
    typedef logic [31:0] t_crc;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam t_byte START_BYTE = 8'h55;
    localparam t_byte STOP_BYTE  = 8'hAA;
    localparam t_crc  CRC_POLY   = 32'hEDB8_8320;
    localparam t_crc  CRC_INIT   = 32'hFFFF_FFFF;

    // One byte through the reflected CRC-32, LSB first; flattens to an XOR net.
    function automatic t_crc crc_feed(input t_crc crc, input t_byte data);
        t_crc c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/rfb_if.sv]
// Handshake channels of the reply frame builder: request items in, frame
// bytes out. Depends on rfb_pkg for the field types.
interface rfb_req_if;
    logic                valid;
    logic                ready;
    logic                kind;
    rfb_pkg::t_byte      peer_addr;
    rfb_pkg::t_byte      own_addr;
    rfb_pkg::t_len       frame_length;
    rfb_pkg::t_byte      service;
    rfb_pkg::t_byte      command;
    rfb_pkg::t_byte      payload_count;
    rfb_pkg::t_byte      data_byte;

    modport source (output valid, kind, peer_addr, own_addr, frame_length, service,
                    command, payload_count, data_byte, input ready);
    modport sink   (input valid, kind, peer_addr, own_addr, frame_length, service,
                    command, payload_count, data_byte, output ready);
endinterface

interface rfb_rsp_if;
    logic                valid;
    logic                ready;
    rfb_pkg::t_byte      out_byte;
    logic                frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

[rtl/core/reply_frame_builder_crc32_unit.sv]
// Reply frame builder with reflected CRC-32, top level.
// Depends on rfb_pkg and the rfb_req_if / rfb_rsp_if channels.
//
// A header item opens a reply frame and produces 0x55, the two swapped
// addresses, the length (low byte first), service and command; each data
// item inside a frame produces its payload byte; the item that completes the
// frame (the last data item, or the header itself when the payload count is
// zero) also produces the four CRC bytes, least significant first, and
// 0xAA 0xAA, with frame_end high on the final 0xAA. Data items outside a
// frame are taken and dropped. The output port moves one byte per cycle while
// the output side is ready; an item carries one byte if it is a plain data
// item, seven if it is a header, six more if it closes a frame, and none if
// it is a dropped data item. The next item is taken in the cycle its
// predecessor hands over its last byte, and a byte waiting in the output
// register does not hold the input side back while the item register is
// free. The CRC is folded in one byte per cycle as the covered bytes go
// out, so the tail reads a settled value.
module reply_frame_builder_crc32_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfb_req_if.sink      i_req,
    rfb_rsp_if.source    o_rsp
);
    import rfb_pkg::*;

    // Byte position within the item currently being sent.
    typedef enum logic [3:0] {
        SL_START, SL_PEER, SL_OWN, SL_LEN_LO, SL_LEN_HI, SL_SVC, SL_CMD,
        SL_DATA, SL_CRC0, SL_CRC1, SL_CRC2, SL_CRC3, SL_STOP0, SL_STOP1
    } t_slot;

    // Frame tracking state
    logic   r_in_frame;
    t_byte  r_bytes_left;
    t_crc   r_crc;

    // Item register
    logic   r_cur_vld;
    t_slot  r_slot;
    logic   r_tail;
    t_byte  r_peer;
    t_byte  r_own;
    t_len   r_len;
    t_byte  r_svc;
    t_byte  r_cmd;
    t_byte  r_data;

    // Output register
    logic   r_out_vld;
    t_byte  r_out_byte;
    logic   r_out_end;

    logic   move;
    logic   last;
    logic   accept;
    logic   load;
    logic   hdr_tail;
    logic   data_tail;
    t_slot  n_slot;
    t_byte  cur_byte;
    t_crc   n_crc;
    t_crc   crc_fin;

    assign crc_fin = r_crc ^ CRC_INIT;

    // Pick the byte of the current slot and the slot after it.
    always_comb begin
        cur_byte = STOP_BYTE;
        n_slot   = r_slot;
        last     = 1'b0;
        unique case (r_slot)
            SL_START:  begin cur_byte = START_BYTE; n_slot = SL_PEER; end
            SL_PEER:   begin cur_byte = r_peer;     n_slot = SL_OWN; end
            SL_OWN:    begin cur_byte = r_own;      n_slot = SL_LEN_LO; end
            SL_LEN_LO: begin cur_byte = r_len[7:0]; n_slot = SL_LEN_HI; end
            SL_LEN_HI: begin cur_byte = r_len[15:8]; n_slot = SL_SVC; end
            SL_SVC:    begin cur_byte = r_svc;      n_slot = SL_CMD; end
            SL_CMD: begin
                cur_byte = r_cmd;
                n_slot   = SL_CRC0;
                last     = !r_tail;
            end
            SL_DATA: begin
                cur_byte = r_data;
                n_slot   = SL_CRC0;
                last     = !r_tail;
            end
            SL_CRC0:   begin cur_byte = crc_fin[7:0];   n_slot = SL_CRC1; end
            SL_CRC1:   begin cur_byte = crc_fin[15:8];  n_slot = SL_CRC2; end
            SL_CRC2:   begin cur_byte = crc_fin[23:16]; n_slot = SL_CRC3; end
            SL_CRC3:   begin cur_byte = crc_fin[31:24]; n_slot = SL_STOP0; end
            SL_STOP0:  begin cur_byte = STOP_BYTE;      n_slot = SL_STOP1; end
            SL_STOP1:  begin cur_byte = STOP_BYTE;      last   = 1'b1; end
            default:   begin cur_byte = STOP_BYTE;      last   = 1'b1; end
        endcase
    end

    // Fold covered bytes into the CRC as they leave; the own (sender) address
    // restarts it, which also drops any abandoned frame.
    always_comb begin
        case (r_slot)
            SL_OWN:                                     n_crc = crc_feed(CRC_INIT, cur_byte);
            SL_LEN_LO, SL_LEN_HI, SL_SVC, SL_CMD, SL_DATA: n_crc = crc_feed(r_crc, cur_byte);
            default:                                    n_crc = r_crc;
        endcase
    end

    // Advance a byte whenever the output register is free or being emptied.
    assign move      = r_cur_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_cur_vld || (move && last);
    assign accept    = i_req.valid && i_req.ready;
    assign load      = accept && ((i_req.kind == KIND_HEADER) || r_in_frame);
    assign hdr_tail  = (i_req.payload_count == 8'd0);
    assign data_tail = (r_bytes_left == 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_crc        <= CRC_INIT;
            r_cur_vld    <= 1'b0;
            r_slot       <= SL_START;
            r_out_vld    <= 1'b0;
        end else begin
            // Frame tracking is settled at accept time.
            if (accept) begin
                if (i_req.kind == KIND_HEADER) begin
                    r_in_frame   <= !hdr_tail;
                    r_bytes_left <= i_req.payload_count;
                end else if (r_in_frame) begin
                    r_in_frame   <= !data_tail;
                    r_bytes_left <= r_bytes_left - 8'd1;
                end
            end

            if (move) begin
                r_crc <= n_crc;
            end

            // Item register: load a new item, step through slots, or drain.
            if (load) begin
                r_cur_vld <= 1'b1;
                r_slot    <= (i_req.kind == KIND_HEADER) ? SL_START : SL_DATA;
                r_tail    <= (i_req.kind == KIND_HEADER) ? hdr_tail : data_tail;
                r_peer    <= i_req.peer_addr;
                r_own     <= i_req.own_addr;
                r_len     <= i_req.frame_length;
                r_svc     <= i_req.service;
                r_cmd     <= i_req.command;
                r_data    <= i_req.data_byte;
            end else if (move) begin
                if (last) begin
                    r_cur_vld <= 1'b0;
                end else begin
                    r_slot <= n_slot;
                end
            end

            // Output register.
            if (move) begin
                r_out_vld  <= 1'b1;
                r_out_byte <= cur_byte;
                r_out_end  <= (r_slot == SL_STOP1);
            end else if (o_rsp.ready) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.out_byte  = r_out_byte;
    assign o_rsp.frame_end = r_out_end;

`ifndef ASSERT_OFF
    // An open frame always expects at least one more payload byte.
    a_open_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_bytes_left != 8'd0))
        else $error("open frame with no payload bytes left");

    // Frame end only marks a stop byte.
    a_end_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_end) |-> (r_out_byte == STOP_BYTE))
        else $error("frame_end on a non-stop byte");

    // The CRC tail is entered only by an item that closes its frame.
    a_tail_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_vld && r_slot == SL_CRC0) |-> r_tail)
        else $error("CRC tail on an item that does not close the frame");

    // A byte moved to the output is visible in the next cycle.
    a_move_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_vld)
        else $error("moved byte lost");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_vld)
        else $error("output valid straight after reset");
`endif

endmodule
